/* src/mspid_pkg.sv */
`default_nettype none

package mspid_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PROP_GAIN      = 3'd0,
        REG_INTEGRAL_GAIN  = 3'd1,
        REG_DERIV_GAIN     = 3'd2,
        REG_INTEGRAL_LIMIT = 3'd3,
        REG_SPEED_SCALE    = 3'd4,
        REG_DUTY_LIMIT     = 3'd5
    } cfg_reg_t;

    localparam logic [15:0] RST_PROP_GAIN      = 16'd3584;
    localparam logic [15:0] RST_INTEGRAL_GAIN  = 16'd435;
    localparam logic [15:0] RST_DERIV_GAIN     = 16'd2816;
    localparam logic [22:0] RST_INTEGRAL_LIMIT = 23'd512000;
    localparam logic [23:0] RST_SPEED_SCALE    = 24'd65536;
    localparam logic [15:0] RST_DUTY_LIMIT     = 16'd8000;

    // Microcode
    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_SPEED_MUL = 3'd0;
    localparam step_t STEP_SPEED     = 3'd1;
    localparam step_t STEP_ERR       = 3'd2;
    localparam step_t STEP_INTEGRATE = 3'd3;
    localparam step_t STEP_MUL_I     = 3'd4;
    localparam step_t STEP_MUL_D     = 3'd5;
    localparam step_t STEP_ACC_D     = 3'd6;
    localparam step_t STEP_EMIT      = 3'd7;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_SPEED,
        MUL_P,
        MUL_I,
        MUL_D
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     ld_speed;
        logic     ld_err;
        logic     upd_state;
        logic     emit;
        logic     br_brake;
        step_t    br_target;
    } uword_t;

    typedef struct packed {
        logic   active;
        uword_t word;
    } ctl_t;

    typedef struct packed {
        logic out_free;
        logic brake;
    } stat_t;

endpackage

`default_nettype wire

/* src/mspid_seq.sv */
`default_nettype none

module mspid_seq (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire mspid_pkg::stat_t stat,
    output mspid_pkg::ctl_t       ctl
);

    logic               busy_reg;
    logic               busy_next;
    mspid_pkg::step_t   step_reg;
    mspid_pkg::step_t   step_next;
    mspid_pkg::uword_t  uword;

    // Program ROM
    always_comb
    begin
        unique case (step_reg)
            mspid_pkg::STEP_SPEED_MUL:
                uword = '{mspid_pkg::MUL_SPEED, mspid_pkg::ACC_HOLD,
                          1'b0, 1'b0, 1'b0, 1'b0, 1'b1, mspid_pkg::STEP_EMIT};
            mspid_pkg::STEP_SPEED:
                uword = '{mspid_pkg::MUL_NONE, mspid_pkg::ACC_HOLD,
                          1'b1, 1'b0, 1'b0, 1'b0, 1'b0, mspid_pkg::STEP_EMIT};
            mspid_pkg::STEP_ERR:
                uword = '{mspid_pkg::MUL_NONE, mspid_pkg::ACC_HOLD,
                          1'b0, 1'b1, 1'b0, 1'b0, 1'b0, mspid_pkg::STEP_EMIT};
            mspid_pkg::STEP_INTEGRATE:
                uword = '{mspid_pkg::MUL_P, mspid_pkg::ACC_HOLD,
                          1'b0, 1'b0, 1'b1, 1'b0, 1'b0, mspid_pkg::STEP_EMIT};
            mspid_pkg::STEP_MUL_I:
                uword = '{mspid_pkg::MUL_I, mspid_pkg::ACC_LOAD,
                          1'b0, 1'b0, 1'b0, 1'b0, 1'b0, mspid_pkg::STEP_EMIT};
            mspid_pkg::STEP_MUL_D:
                uword = '{mspid_pkg::MUL_D, mspid_pkg::ACC_ADD,
                          1'b0, 1'b0, 1'b0, 1'b0, 1'b0, mspid_pkg::STEP_EMIT};
            mspid_pkg::STEP_ACC_D:
                uword = '{mspid_pkg::MUL_NONE, mspid_pkg::ACC_ADD,
                          1'b0, 1'b0, 1'b0, 1'b0, 1'b0, mspid_pkg::STEP_EMIT};
            mspid_pkg::STEP_EMIT:
                uword = '{mspid_pkg::MUL_NONE, mspid_pkg::ACC_HOLD,
                          1'b0, 1'b0, 1'b0, 1'b1, 1'b0, mspid_pkg::STEP_EMIT};
            default:
                uword = '{mspid_pkg::MUL_NONE, mspid_pkg::ACC_HOLD,
                          1'b0, 1'b0, 1'b0, 1'b0, 1'b0, mspid_pkg::STEP_EMIT};
        endcase
    end

    // Step counter and jumps
    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                step_next = mspid_pkg::STEP_SPEED_MUL;
            end
        end
        else if (uword.emit)
        begin
            // hold on the emit step until the output register is free
            if (stat.out_free)
            begin
                busy_next = 1'b0;
            end
        end
        else if (uword.br_brake && stat.brake)
        begin
            step_next = uword.br_target;
        end
        else
        begin
            step_next = step_reg + mspid_pkg::step_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= mspid_pkg::STEP_SPEED_MUL;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    assign ctl.active = busy_reg;
    assign ctl.word   = uword;

    a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && uword.emit && !stat.out_free)
        |=> (busy_reg && step_reg == $past(step_reg)))
        else $error("sequencer left the emit step while the output was full");

    a_no_early_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !uword.emit) |=> busy_reg)
        else $error("sequencer went idle before emitting a result");

    a_start_at_top: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy_reg && start) |=> (busy_reg && step_reg == mspid_pkg::STEP_SPEED_MUL))
        else $error("program did not start at its first step");

endmodule

`default_nettype wire

/* src/mspid_datapath.sv */
`default_nettype none

module mspid_datapath #(
    parameter int NUM_MOTORS = 2,
    parameter int SPEED_BITS = 24
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_wen,
    input  wire logic [mspid_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [mspid_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                  in_load,
    input  wire logic                                  in_sel,
    input  wire logic [15:0]                           in_count,
    input  wire logic [23:0]                           in_target,
    input  wire logic                                  in_brake,
    input  wire mspid_pkg::ctl_t                       ctl,
    output mspid_pkg::stat_t                           stat,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic                                       out_motor,
    output logic [15:0]                                out_in1,
    output logic [15:0]                                out_in2,
    output logic signed [16:0]                         out_drive,
    output logic                                       out_braking
);

    localparam int SB    = SPEED_BITS;
    localparam int SW    = SB - 1;
    localparam int SB1   = SB + 1;
    localparam int IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
    localparam int MB    = (SB1 > 25) ? SB1 : 25;
    localparam int PW    = 17 + MB;
    localparam int AW    = PW + 2;
    localparam logic [31:0] SMAX32 = 32'((64'd1 << (SB - 1)) - 64'd1);

    // configuration registers
    logic [15:0] pgain_reg;
    logic [15:0] igain_reg;
    logic [15:0] dgain_reg;
    logic [22:0] ilimit_reg;
    logic [23:0] scale_reg;
    logic [15:0] duty_reg;

    // item registers
    logic        sel_reg;
    logic [15:0] count_reg;
    logic [23:0] target_reg;
    logic        brake_reg;

    // working registers
    logic signed [PW-1:0] prod_reg;
    logic signed [AW-1:0] acc_reg;
    logic [SW-1:0]        speed_reg;
    logic signed [SB-1:0] err_reg;
    logic signed [SB-1:0] sum_reg;
    logic signed [SB:0]   diff_reg;

    // per-motor state
    logic signed [SB-1:0] isum_reg [NUM_MOTORS];
    logic signed [SB-1:0] prev_reg [NUM_MOTORS];

    // output register
    logic               out_valid_reg;
    logic               out_motor_reg;
    logic [15:0]        out_in1_reg;
    logic [15:0]        out_in2_reg;
    logic signed [16:0] out_drive_reg;
    logic               out_braking_reg;

    logic [IDX_W-1:0]     idx;
    logic [23:0]          tabs;
    logic [SW-1:0]        tmag;
    logic [31:0]          speed_raw;
    logic [SW-1:0]        speed_next;
    logic [SW+1:0]        tmag3;
    logic [SW-1:0]        actual;
    logic signed [SB-1:0] err_next;
    logic [SW-1:0]        lim;
    logic signed [SB:0]   lim_pos;
    logic signed [SB:0]   lim_neg;
    logic signed [SB:0]   sum_raw;
    logic signed [SB:0]   sum_clamped;
    logic signed [SB:0]   diff_next;
    logic signed [16:0]   mul_a;
    logic signed [MB-1:0] mul_b;
    logic signed [PW-1:0] prod;
    logic [AW-1:0]        acc_abs;
    logic [15:0]          mag;
    logic [15:0]          mag_eff;
    logic                 neg;
    logic                 brk_out;
    logic                 fwd;
    logic signed [16:0]   drive;
    logic [15:0]          in1;
    logic [15:0]          in2;
    logic                 out_free;

    assign idx = (NUM_MOTORS > 1) ? IDX_W'(sel_reg) : '0;

    // speed and error
    assign tabs       = target_reg[23] ? 24'(-target_reg) : target_reg;
    assign tmag       = ({8'd0, tabs} > SMAX32) ? SW'(SMAX32) : SW'(tabs);
    assign speed_raw  = 32'(prod_reg[39:8]);
    assign speed_next = (speed_raw > SMAX32) ? SW'(SMAX32) : SW'(speed_raw);
    assign tmag3      = {2'b00, tmag} + {1'b0, tmag, 1'b0};
    assign actual     = ({2'b00, speed_reg} > tmag3) ? tmag3[SW-1:0] : speed_reg;
    assign err_next   = $signed({1'b0, tmag}) - $signed({1'b0, actual});

    // clamped error sum and difference
    assign lim     = ({9'd0, ilimit_reg} > SMAX32) ? SW'(SMAX32) : SW'(ilimit_reg);
    assign lim_pos = $signed({2'b00, lim});
    assign lim_neg = -lim_pos;
    assign sum_raw = SB1'(isum_reg[idx]) + SB1'(err_reg);

    always_comb
    begin
        if (sum_raw >= lim_pos)
        begin
            sum_clamped = lim_pos;
        end
        else if (sum_raw <= lim_neg)
        begin
            sum_clamped = lim_neg;
        end
        else
        begin
            sum_clamped = sum_raw;
        end
    end

    assign diff_next = SB1'(err_reg) - SB1'(prev_reg[idx]);

    // shared multiplier
    always_comb
    begin
        case (ctl.word.mul_sel)
            mspid_pkg::MUL_SPEED:
            begin
                mul_a = $signed({1'b0, count_reg});
                mul_b = $signed(MB'({1'b0, scale_reg}));
            end
            mspid_pkg::MUL_P:
            begin
                mul_a = $signed({1'b0, pgain_reg});
                mul_b = MB'(err_reg);
            end
            mspid_pkg::MUL_I:
            begin
                mul_a = $signed({1'b0, igain_reg});
                mul_b = MB'(sum_reg);
            end
            mspid_pkg::MUL_D:
            begin
                mul_a = $signed({1'b0, dgain_reg});
                mul_b = MB'(diff_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // output mapping; acc is Q.16, truncated toward zero
    assign acc_abs = acc_reg[AW-1] ? AW'(-acc_reg) : AW'(acc_reg);
    assign mag     = (acc_abs[AW-1:16] > (AW-16)'(duty_reg)) ? duty_reg : acc_abs[31:16];
    assign mag_eff = brake_reg ? 16'd0 : mag;
    assign neg     = acc_reg[AW-1] ^ target_reg[23];
    assign brk_out = (mag_eff == 16'd0);
    assign fwd     = (!neg) ^ sel_reg;
    assign drive   = brk_out ? 17'sd0 :
                     (neg ? -$signed({1'b0, mag_eff}) : $signed({1'b0, mag_eff}));
    assign in1     = brk_out ? duty_reg : (fwd ? mag_eff : 16'd0);
    assign in2     = brk_out ? duty_reg : (fwd ? 16'd0 : mag_eff);

    assign out_free = !out_valid_reg || out_ready;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pgain_reg  <= mspid_pkg::RST_PROP_GAIN;
            igain_reg  <= mspid_pkg::RST_INTEGRAL_GAIN;
            dgain_reg  <= mspid_pkg::RST_DERIV_GAIN;
            ilimit_reg <= mspid_pkg::RST_INTEGRAL_LIMIT;
            scale_reg  <= mspid_pkg::RST_SPEED_SCALE;
            duty_reg   <= mspid_pkg::RST_DUTY_LIMIT;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                mspid_pkg::REG_PROP_GAIN:      pgain_reg  <= cfg_data[15:0];
                mspid_pkg::REG_INTEGRAL_GAIN:  igain_reg  <= cfg_data[15:0];
                mspid_pkg::REG_DERIV_GAIN:     dgain_reg  <= cfg_data[15:0];
                mspid_pkg::REG_INTEGRAL_LIMIT: ilimit_reg <= cfg_data[22:0];
                mspid_pkg::REG_SPEED_SCALE:    scale_reg  <= cfg_data[23:0];
                mspid_pkg::REG_DUTY_LIMIT:     duty_reg   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // item and working registers (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            sel_reg    <= in_sel;
            count_reg  <= in_count;
            target_reg <= in_target;
            brake_reg  <= in_brake;
        end
        if (ctl.active)
        begin
            if (ctl.word.mul_sel != mspid_pkg::MUL_NONE)
            begin
                prod_reg <= prod;
            end
            if (ctl.word.ld_speed)
            begin
                speed_reg <= speed_next;
            end
            if (ctl.word.ld_err)
            begin
                err_reg <= err_next;
            end
            if (ctl.word.upd_state)
            begin
                sum_reg  <= SB'(sum_clamped);
                diff_reg <= diff_next;
            end
            case (ctl.word.acc_op)
                mspid_pkg::ACC_LOAD: acc_reg <= AW'(prod_reg);
                mspid_pkg::ACC_ADD:  acc_reg <= acc_reg + AW'(prod_reg);
                default: ;
            endcase
            if (ctl.word.emit && out_free)
            begin
                out_motor_reg   <= sel_reg;
                out_in1_reg     <= in1;
                out_in2_reg     <= in2;
                out_drive_reg   <= drive;
                out_braking_reg <= brk_out;
            end
        end
    end

    // per-motor controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_MOTORS; i++)
            begin
                isum_reg[i] <= '0;
                prev_reg[i] <= '0;
            end
        end
        else if (ctl.active && ctl.word.upd_state)
        begin
            isum_reg[idx] <= SB'(sum_clamped);
            prev_reg[idx] <= err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.active && ctl.word.emit && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign stat.out_free = out_free;
    assign stat.brake    = brake_reg;

    assign out_valid   = out_valid_reg;
    assign out_motor   = out_motor_reg;
    assign out_in1     = out_in1_reg;
    assign out_in2     = out_in2_reg;
    assign out_drive   = out_drive_reg;
    assign out_braking = out_braking_reg;

    a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(ctl.active && ctl.word.emit))
        else $error("result appeared without an emit step");

    a_brake_no_update: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.active && ctl.word.upd_state) |-> !brake_reg)
        else $error("controller state updated on a brake request");

    a_braking_zero_drive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_braking_reg)
        |-> (out_drive_reg == 17'sd0 && out_in1_reg == out_in2_reg))
        else $error("braking result carries a drive value");

endmodule

`default_nettype wire

/* src/motor_speed_pid_hbridge_core.sv */
// Speed controller for up to NUM_MOTORS DC motors on H-bridges.
// Input stream (s_axis): one transfer is one control tick for one motor: the
//   encoder count since that motor's last tick, a signed Q16.8 target speed,
//   the motor select and a brake flag. Output stream (m_axis): one transfer
//   per input, with the two bridge compare values, the signed drive and a
//   braking flag.
// Configuration: cfg_wen/cfg_index/cfg_data write the gains, limits and
//   speed scale; write only while the core is idle. Unknown indexes are
//   ignored.
// Program: a small microcode program (8 steps) runs on one shared 17 x 25
//   multiplier and an accumulator. A new tick is taken only once the
//   program for the last one has ended. A brake request jumps straight
//   from the first step to the emit step.
// Stall: the result sits in an output register; while it waits the core still
//   takes and processes the next tick, then holds on its emit step until the
//   register is free. s_axis_tready is low while a program runs.
// Reset: clears the per-motor error sums and previous errors, loads the
//   register defaults and leaves both streams empty.
`default_nettype none

module motor_speed_pid_hbridge_core #(
    parameter int NUM_MOTORS = 2,
    parameter int SPEED_BITS = 24
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              cfg_wen,
    input  wire logic [mspid_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [mspid_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [39:0]                       s_axis_tdata,  // encoder_count, set_speed
    input  wire logic [1:0]                        s_axis_tuser,  // motor_sel, brake

    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [55:0]                            m_axis_tdata,  // in1_compare, in2_compare,
                                                                  // drive_value, zero pad
    output logic [1:0]                             m_axis_tuser   // motor_out, braking
);

    mspid_pkg::ctl_t  ctl;
    mspid_pkg::stat_t stat;

    logic               in_xfer;
    logic               out_motor;
    logic [15:0]        out_in1;
    logic [15:0]        out_in2;
    logic signed [16:0] out_drive;
    logic               out_braking;

    // ready whenever no program is running
    assign s_axis_tready = !ctl.active;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    mspid_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_xfer),
        .stat  (stat),
        .ctl   (ctl)
    );

    mspid_datapath #(
        .NUM_MOTORS (NUM_MOTORS),
        .SPEED_BITS (SPEED_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wen     (cfg_wen),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_load     (in_xfer),
        .in_sel      (s_axis_tuser[0]),
        .in_count    (s_axis_tdata[15:0]),
        .in_target   (s_axis_tdata[39:16]),
        .in_brake    (s_axis_tuser[1]),
        .ctl         (ctl),
        .stat        (stat),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_motor   (out_motor),
        .out_in1     (out_in1),
        .out_in2     (out_in2),
        .out_drive   (out_drive),
        .out_braking (out_braking)
    );

    assign m_axis_tdata = {7'd0, out_drive, out_in2, out_in1};
    assign m_axis_tuser = {out_braking, out_motor};

endmodule

`default_nettype wire

/* tb/testbench.sv */
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    // Self-checking bench for the two-motor speed PID / H-bridge core.
    // Stimulus runs through the s_axis stream, results are collected from the
    // m_axis stream and compared in order against a local model of the PID.
    // A short directed table comes first, then random ticks under several
    // register settings, from all-zero to all-ones, with random gaps on both
    // streams.

    localparam int  NUM_MOTORS    = 2;
    localparam longint SPEED_MAX  = (64'sd1 <<< 23) - 1;  // Q16.8 speed range
    localparam int  NUM_PHASES    = 8;
    localparam int  PHASE_TICKS   = 250;
    localparam int  HOLD_CYCLES   = 400;                  // long m_axis hold-off
    localparam int  SETTLE_CYCLES = 20;                   // longer than one program run
    localparam int  STALL_LIMIT   = 4000;                 // cycles with no transfer
    localparam int  MAX_REPORTS   = 10;
    localparam int  NUM_ROWS      = 20;

    // indexes the core does not decode; writes there must be dropped
    localparam logic [mspid_pkg::CFG_INDEX_W-1:0] SPARE_INDEX_LO = 3'd6;
    localparam logic [mspid_pkg::CFG_INDEX_W-1:0] SPARE_INDEX_HI = 3'd7;

    typedef struct {
        logic               sel;
        logic [15:0]        count;
        logic signed [23:0] target;
        logic               brake;
    } tick_t;

    typedef struct {
        logic               motor;
        logic [15:0]        in1;
        logic [15:0]        in2;
        logic signed [16:0] drive;
        logic               braking;
    } bridge_cmd_t;

    // directed row: stimulus, then a typed expectation when chk is set
    typedef struct packed {
        logic        sel;
        logic        brake;
        logic [15:0] count;
        logic [23:0] target;
        logic        chk;
        logic [15:0] in1;
        logic [15:0] in2;
        logic [16:0] drive;
        logic        braking;
    } tick_row_t;

    localparam tick_row_t TICK_TABLE [NUM_ROWS] = '{
        // brake requests, all at reset levels
        '{1'b0, 1'b1, 16'hFFFF, 24'h7FFFFF, 1'b1, 16'd8000, 16'd8000, 17'd0, 1'b1},
        '{1'b1, 1'b1, 16'h0000, 24'h800000, 1'b1, 16'd8000, 16'd8000, 17'd0, 1'b1},
        // zero target on clean state: zero drive, bridge brakes
        '{1'b0, 1'b0, 16'h0000, 24'h000000, 1'b1, 16'd8000, 16'd8000, 17'd0, 1'b1},
        '{1'b1, 1'b0, 16'hFFFF, 24'h000000, 1'b1, 16'd8000, 16'd8000, 17'd0, 1'b1},
        // full-scale targets, both directions, both motors
        '{1'b0, 1'b0, 16'h0000, 24'h7FFFFF, 1'b0, 16'd0, 16'd0, 17'd0, 1'b0},
        '{1'b1, 1'b0, 16'h0000, 24'h800000, 1'b0, 16'd0, 16'd0, 17'd0, 1'b0},
        '{1'b0, 1'b0, 16'hFFFF, 24'h800000, 1'b0, 16'd0, 16'd0, 17'd0, 1'b0},
        '{1'b1, 1'b0, 16'hFFFF, 24'h7FFFFF, 1'b0, 16'd0, 16'd0, 17'd0, 1'b0},
        // on speed, forward and reverse
        '{1'b0, 1'b0, 16'h0064, 24'h006400, 1'b0, 16'd0, 16'd0, 17'd0, 1'b0},
        '{1'b1, 1'b0, 16'h0064, 24'hFF9C00, 1'b0, 16'd0, 16'd0, 17'd0, 1'b0},
        // measured speed clamped to three times the target
        '{1'b0, 1'b0, 16'hFFFF, 24'h000100, 1'b0, 16'd0, 16'd0, 17'd0, 1'b0},
        // zero target after error: integral and derivative terms drive
        '{1'b0, 1'b0, 16'h0000, 24'h000000, 1'b0, 16'd0, 16'd0, 17'd0, 1'b0},
        '{1'b1, 1'b0, 16'h0000, 24'h000000, 1'b0, 16'd0, 16'd0, 17'd0, 1'b0},
        // brake with live state: state must be left alone
        '{1'b0, 1'b1, 16'h1234, 24'h123456, 1'b1, 16'd8000, 16'd8000, 17'd0, 1'b1},
        '{1'b0, 1'b0, 16'h0000, 24'h000001, 1'b0, 16'd0, 16'd0, 17'd0, 1'b0},
        '{1'b1, 1'b0, 16'h0000, 24'hFFFFFF, 1'b0, 16'd0, 16'd0, 17'd0, 1'b0},
        '{1'b0, 1'b0, 16'hAAAA, 24'h555555, 1'b0, 16'd0, 16'd0, 17'd0, 1'b0},
        '{1'b1, 1'b0, 16'h5555, 24'hAAAAAA, 1'b0, 16'd0, 16'd0, 17'd0, 1'b0},
        '{1'b0, 1'b0, 16'h0001, 24'h000080, 1'b0, 16'd0, 16'd0, 17'd0, 1'b0},
        '{1'b1, 1'b1, 16'hFFFF, 24'h000000, 1'b1, 16'd8000, 16'd8000, 17'd0, 1'b1}
    };

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_wen = 1'b0;
    logic [mspid_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [mspid_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [39:0]                       s_axis_tdata = '0;    // encoder_count, set_speed
    logic [1:0]                        s_axis_tuser = '0;    // motor_sel, brake
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [55:0]                       m_axis_tdata;         // in1_compare, in2_compare,
                                                             // drive_value, zero pad
    logic [1:0]                        m_axis_tuser;         // motor_out, braking

    motor_speed_pid_hbridge_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    // local copy of the register file
    logic [15:0] k_prop      = mspid_pkg::RST_PROP_GAIN;
    logic [15:0] k_int       = mspid_pkg::RST_INTEGRAL_GAIN;
    logic [15:0] k_der       = mspid_pkg::RST_DERIV_GAIN;
    logic [22:0] sum_limit   = mspid_pkg::RST_INTEGRAL_LIMIT;
    logic [23:0] pulse_scale = mspid_pkg::RST_SPEED_SCALE;
    logic [15:0] duty_max    = mspid_pkg::RST_DUTY_LIMIT;

    // per-motor controller state, Q16.8
    longint err_sum  [NUM_MOTORS] = '{default: 0};
    longint last_err [NUM_MOTORS] = '{default: 0};

    bridge_cmd_t pending_cmds[$];

    int  mismatches      = 0;
    int  ticks_sent      = 0;
    int  brake_ticks     = 0;
    int  results_checked = 0;
    int  settings_used   = 1;
    bit  hold_req        = 1'b0;
    bit  no_idle         = 1'b0;

    // one control tick through the PID; updates the local state
    function automatic bridge_cmd_t pid_tick(input tick_t t);
        longint speed, tmag, lim, err, esum, diff, acc, amag, drv, tgt;
        int m;
        bridge_cmd_t r;
        m   = (t.sel < NUM_MOTORS) ? int'(t.sel) : NUM_MOTORS - 1;
        tgt = longint'(t.target);
        drv = 0;
        if (!t.brake)
        begin
            speed = (longint'(t.count) * longint'(pulse_scale)) >>> 8;
            if (speed > SPEED_MAX)
                speed = SPEED_MAX;
            tmag = (tgt < 0) ? -tgt : tgt;
            if (tmag > SPEED_MAX)
                tmag = SPEED_MAX;
            if (speed > 3 * tmag)
                speed = 3 * tmag;
            err = tmag - speed;
            lim = longint'(sum_limit);
            if (lim > SPEED_MAX)
                lim = SPEED_MAX;
            esum = err_sum[m] + err;
            if (esum >= lim)
                esum = lim;
            else if (esum <= -lim)
                esum = -lim;
            err_sum[m] = esum;
            diff = err - last_err[m];
            last_err[m] = err;
            acc = longint'(k_prop) * err + longint'(k_int) * esum + longint'(k_der) * diff;
            amag = ((acc < 0) ? -acc : acc) >>> 16;
            if (amag > longint'(duty_max))
                amag = longint'(duty_max);
            drv = (acc < 0) ? -amag : amag;
            if (tgt < 0)
                drv = -drv;
        end
        r.motor   = t.sel;
        r.braking = (drv == 0);
        r.drive   = drv[16:0];
        if (r.braking)
        begin
            r.in1 = duty_max;
            r.in2 = duty_max;
        end
        else if ((drv > 0) != (t.sel == 1'b1))
        begin
            r.in1 = (drv < 0) ? 16'(-drv) : 16'(drv);
            r.in2 = '0;
        end
        else
        begin
            r.in1 = '0;
            r.in2 = (drv < 0) ? 16'(-drv) : 16'(drv);
        end
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // random tick; counts often land near the target so the loop is exercised
    function automatic tick_t random_tick();
        tick_t  t;
        int     r;
        longint mag, tgt, want;
        t.sel   = 1'($urandom_range(0, 1));
        t.brake = ($urandom_range(0, 9) == 0);
        r = $urandom_range(0, 99);
        if (r < 10)
            mag = 0;
        else if (r < 18)
            mag = $urandom_range(0, 1) ? 8388607 : 8388608;
        else if (r < 60)
            mag = $urandom_range(0, 60000);
        else if (r < 85)
            mag = $urandom_range(0, 2000000);
        else
            mag = $urandom_range(0, 8388608);
        tgt = (mag > 8388607 || $urandom_range(0, 1)) ? -mag : mag;
        t.target = tgt[23:0];
        r = $urandom_range(0, 99);
        if (r < 45 && pulse_scale != 0)
        begin
            want = ((mag <<< 8) / longint'(pulse_scale)) + $urandom_range(0, 40) - 20;
            t.count = (want < 0) ? 16'd0 : (want > 65535) ? 16'hFFFF : want[15:0];
        end
        else if (r < 75)
            t.count = 16'($urandom_range(0, 500));
        else
            t.count = 16'($urandom());
        return t;
    endfunction

    // offer one tick, wait for the transfer, then queue what it should produce
    task automatic send_tick(input tick_t t, input bit typed, input bridge_cmd_t typed_cmd);
        int gap;
        bridge_cmd_t cmd;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {t.target, t.count};
        s_axis_tuser  <= {t.brake, t.sel};
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        cmd = pid_tick(t);
        pending_cmds.push_back(typed ? typed_cmd : cmd);
        ticks_sent++;
        if (t.brake)
            brake_ticks++;
    endtask

    // stop offering, let every result out and the core fall idle
    task automatic settle_core();
        s_axis_tvalid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write one register; wen is left high for back-to-back writes
    task automatic write_reg(input logic [mspid_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [23:0] val);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            mspid_pkg::REG_PROP_GAIN:      k_prop      = val[15:0];
            mspid_pkg::REG_INTEGRAL_GAIN:  k_int       = val[15:0];
            mspid_pkg::REG_DERIV_GAIN:     k_der       = val[15:0];
            mspid_pkg::REG_INTEGRAL_LIMIT: sum_limit   = val[22:0];
            mspid_pkg::REG_SPEED_SCALE:    pulse_scale = val;
            mspid_pkg::REG_DUTY_LIMIT:     duty_max    = val[15:0];
            default: ;
        endcase
    endtask

    task automatic apply_phase(input int ph);
        logic [23:0] v [6];
        case (ph)
            1:
            begin
                v = '{mspid_pkg::RST_PROP_GAIN, mspid_pkg::RST_INTEGRAL_GAIN,
                      mspid_pkg::RST_DERIV_GAIN, mspid_pkg::RST_INTEGRAL_LIMIT,
                      mspid_pkg::RST_SPEED_SCALE, mspid_pkg::RST_DUTY_LIMIT};
            end
            2:  v = '{default: 24'hFFFFFF};   // all-ones, upper bits masked off
            3:  v = '{default: 24'h000000};
            4:
            begin
                v = '{24'($urandom_range(0, 8000)), 24'($urandom_range(0, 2000)),
                      24'($urandom_range(0, 8000)), 24'd0, 24'd256, 24'hFFFF};
            end
            5:
            begin
                v = '{24'($urandom()), 24'($urandom()), 24'($urandom()),
                      24'($urandom()), 24'($urandom()), 24'($urandom())};
            end
            6:
            begin
                v = '{mspid_pkg::RST_PROP_GAIN, mspid_pkg::RST_INTEGRAL_GAIN,
                      mspid_pkg::RST_DERIV_GAIN,
                      24'($urandom_range(0, 1000000)), 24'($urandom_range(1000, 200000)),
                      24'($urandom_range(100, 20000))};
            end
            default:
            begin
                v = '{24'($urandom()), 24'($urandom()), 24'($urandom()),
                      24'($urandom()), 24'($urandom_range(0, 131072)),
                      24'($urandom_range(1, 10))};
            end
        endcase
        for (int i = 0; i < 6; i++)
            write_reg(mspid_pkg::cfg_reg_t'(i), v[i]);
        if (ph == 1)
        begin
            // undecoded indexes: must not disturb anything
            write_reg(SPARE_INDEX_LO, 24'($urandom()));
            write_reg(SPARE_INDEX_HI, 24'($urandom()));
        end
        cfg_wen <= 1'b0;
        settings_used++;
    endtask

    // result side: random back-pressure, plus one long hold-off on request
    initial
    begin
        int stall_left;
        bridge_cmd_t want;
        logic [16:0] got_drive;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_drive = m_axis_tdata[48:32];
                if (pending_cmds.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result: motor %0d in1 %0d in2 %0d drive %0d brk %0d",
                                 m_axis_tuser[0], m_axis_tdata[15:0], m_axis_tdata[31:16],
                                 $signed(got_drive), m_axis_tuser[1]);
                end
                else
                begin
                    want = pending_cmds.pop_front();
                    results_checked++;
                    if (m_axis_tuser[0] !== want.motor || m_axis_tdata[15:0] !== want.in1 ||
                        m_axis_tdata[31:16] !== want.in2 || got_drive !== want.drive ||
                        m_axis_tuser[1] !== want.braking)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                        begin
                            $display("result %0d: expected motor %0d in1 %0d in2 %0d drive %0d brk %0d",
                                     results_checked, want.motor, want.in1, want.in2,
                                     want.drive, want.braking);
                            $display("result %0d:      got motor %0d in1 %0d in2 %0d drive %0d brk %0d",
                                     results_checked, m_axis_tuser[0], m_axis_tdata[15:0],
                                     m_axis_tdata[31:16], $signed(got_drive), m_axis_tuser[1]);
                        end
                    end
                end
            end
            if (hold_req)
            begin
                stall_left = HOLD_CYCLES;
                hold_req   = 1'b0;
            end
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!no_idle && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // watchdog: too long without any transfer on either stream
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                         quiet, pending_cmds.size());
                $display("motor_speed_pid_hbridge_core regression: fail");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        tick_t       t;
        bridge_cmd_t typed_cmd;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at reset settings
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            t.sel     = TICK_TABLE[i].sel;
            t.brake   = TICK_TABLE[i].brake;
            t.count   = TICK_TABLE[i].count;
            t.target  = signed'(TICK_TABLE[i].target);
            typed_cmd.motor   = TICK_TABLE[i].sel;
            typed_cmd.in1     = TICK_TABLE[i].in1;
            typed_cmd.in2     = TICK_TABLE[i].in2;
            typed_cmd.drive   = signed'(TICK_TABLE[i].drive);
            typed_cmd.braking = TICK_TABLE[i].braking;
            send_tick(t, TICK_TABLE[i].chk, typed_cmd);
        end

        // random ticks, one register setting per phase
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph > 0)
            begin
                settle_core();
                apply_phase(ph);
            end
            no_idle = (ph == 6);
            // result side stalls while ticks keep coming: input backs up
            if (ph == 1)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_TICKS; n++)
            begin
                // sender drains fully once mid-run
                if (ph == 5 && n == PHASE_TICKS / 2)
                    settle_core();
                send_tick(random_tick(), 1'b0, typed_cmd);
            end
        end

        settle_core();
        $display("%0d ticks sent (%0d brake requests) across %0d register settings;",
                 ticks_sent, brake_ticks, settings_used);
        $display("%0d results checked, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0 && pending_cmds.size() == 0)
            $display("motor_speed_pid_hbridge_core regression: pass");
        else
            $display("motor_speed_pid_hbridge_core regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
src/mspid_pkg.sv
src/mspid_seq.sv
src/mspid_datapath.sv
src/motor_speed_pid_hbridge_core.sv
tb/testbench.sv
